// ===== rtl/llsm_pkg.sv =====
// Shared types and constants for the linked list slot manager.
// No dependencies; every other file except llsm_ram refers to it by scoped names.
package llsm_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = 6;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int CNT_W = 7;
  localparam logic [POS_W-1:0] POS_NONE = 7'h7F;

  typedef enum logic [2:0] {
    FN_APPEND, FN_PREPEND, FN_INSERT, FN_REMOVE, FN_SEARCH, FN_GET, FN_SET, FN_UNUSED
  } func_t;

  typedef enum logic [1:0] {
    ST_OK, ST_BAD_POS, ST_FULL, ST_NOT_FOUND
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_FAIL, OP_TAKE_RD, OP_TAKE, OP_APP_START, OP_APP_WALK,
    OP_INS_W1, OP_INS_W2, OP_RM_RD, OP_RM_LATCH, OP_RM_WALK, OP_RM_FIX,
    OP_RM_FREE, OP_SR_START, OP_SR_STEP
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_TAKE, S_APP_START, S_APP_WALK, S_INS_W1, S_INS_W2,
    S_RM_LATCH, S_RM_WALK, S_RM_FIX, S_RM_FREE, S_SR_STEP, S_GET, S_DONE
  } ctl_state_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
    logic    get_final;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  pos_ok;
    logic  free_ok;
    logic  head_ok;
    logic  app_more;
    logic  rm_more;
    logic  sr_more;
    logic  hit;
  } dp_stat_t;

endpackage

// ===== rtl/llsm_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
// Depends on llsm_pkg for widths.
interface llsm_req_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       func;
  logic signed [llsm_pkg::POS_W-1:0] position;
  logic [llsm_pkg::VAL_W-1:0]       value;
  modport source (output valid, func, position, value, input ready);
  modport sink (input valid, func, position, value, output ready);
endinterface

// ===== rtl/llsm_rsp_if.sv =====
// Response channel: valid/ready handshake with the result fields.
// Depends on llsm_pkg for widths.
interface llsm_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [llsm_pkg::POS_W-1:0] out_position;
  logic [llsm_pkg::VAL_W-1:0]        out_value;
  logic [llsm_pkg::CNT_W-1:0]        list_size;
  modport source (output valid, status, out_position, out_value, list_size, input ready);
  modport sink (input valid, status, out_position, out_value, list_size, output ready);
endinterface

// ===== rtl/llsm_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module llsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/llsm_datapath.sv =====
// Datapath: head and free pointers, occupancy, link and value RAMs, walk and result registers.
// Depends on llsm_pkg and llsm_ram; driven by llsm_ctrl through dp_cmd_t.
module llsm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  llsm_pkg::dp_cmd_t                   cmd,
  input  logic [2:0]                          func,
  input  logic [llsm_pkg::POS_W-1:0]          position,
  input  logic [llsm_pkg::VAL_W-1:0]          value,
  output llsm_pkg::dp_stat_t                  stat,
  output logic [1:0]                          status,
  output logic [llsm_pkg::POS_W-1:0]          out_position,
  output logic [llsm_pkg::VAL_W-1:0]          out_value,
  output logic [llsm_pkg::CNT_W-1:0]          list_size
);

  llsm_pkg::func_t                 req_func;
  logic [llsm_pkg::POS_W-1:0]      req_pos;
  logic [llsm_pkg::VAL_W-1:0]      req_val;
  logic [llsm_pkg::POS_W-1:0]      list_head;
  logic [llsm_pkg::POS_W-1:0]      free_head;
  logic [llsm_pkg::POS_W-1:0]      cur;
  logic [llsm_pkg::POS_W-1:0]      prev;
  logic [llsm_pkg::POS_W-1:0]      succ;
  logic [llsm_pkg::POS_W-1:0]      s_slot;
  logic [llsm_pkg::CNT_W-1:0]      count;
  logic [llsm_pkg::CNT_W-1:0]      n;
  logic                            use_rd;
  logic [llsm_pkg::SLOTS-1:0]      in_use;
  logic [llsm_pkg::SLOTS-1:0]      lvld;
  logic                            lvld_q;
  logic [llsm_pkg::POS_W-1:0]      ldef_q;
  llsm_pkg::status_t               res_status;
  logic [llsm_pkg::POS_W-1:0]      res_pos;
  logic [llsm_pkg::VAL_W-1:0]      res_val;

  logic                            l_we;
  logic [llsm_pkg::IDX_W-1:0]      l_waddr;
  logic [llsm_pkg::POS_W-1:0]      l_wdata;
  logic [llsm_pkg::POS_W-1:0]      l_rdata;
  logic                            v_we;
  logic [llsm_pkg::IDX_W-1:0]      v_waddr;
  logic [llsm_pkg::VAL_W-1:0]      v_wdata;
  logic [llsm_pkg::VAL_W-1:0]      v_rdata;
  logic                            l_re;
  logic                            v_re;
  logic [llsm_pkg::IDX_W-1:0]      rd_addr;
  logic [llsm_pkg::POS_W-1:0]      rd_link;
  logic [llsm_pkg::POS_W-1:0]      cur_w;

  assign rd_link = lvld_q ? l_rdata : ldef_q;
  assign cur_w   = use_rd ? rd_link : cur;

  always_comb begin
    stat.func     = req_func;
    stat.pos_ok   = !req_pos[llsm_pkg::POS_W-1] && in_use[req_pos[llsm_pkg::IDX_W-1:0]];
    stat.free_ok  = !free_head[llsm_pkg::POS_W-1];
    stat.head_ok  = !list_head[llsm_pkg::POS_W-1];
    stat.app_more = (n < llsm_pkg::CNT_W'(llsm_pkg::SLOTS)) && !rd_link[llsm_pkg::POS_W-1];
    stat.rm_more  = (n < llsm_pkg::CNT_W'(llsm_pkg::SLOTS)) && !cur_w[llsm_pkg::POS_W-1]
                    && (cur_w != req_pos);
    stat.sr_more  = (n < llsm_pkg::CNT_W'(llsm_pkg::SLOTS - 1)) && !rd_link[llsm_pkg::POS_W-1];
    stat.hit      = (v_rdata == req_val);
  end

  always_comb begin
    l_we    = 1'b0;
    l_waddr = '0;
    l_wdata = '0;
    v_we    = 1'b0;
    v_waddr = req_pos[llsm_pkg::IDX_W-1:0];
    v_wdata = req_val;
    l_re    = 1'b0;
    v_re    = 1'b0;
    rd_addr = req_pos[llsm_pkg::IDX_W-1:0];
    case (cmd.op)
      llsm_pkg::OP_TAKE_RD: begin
        l_re    = 1'b1;
        rd_addr = free_head[llsm_pkg::IDX_W-1:0];
      end
      llsm_pkg::OP_TAKE: begin
        v_we    = 1'b1;
        v_waddr = free_head[llsm_pkg::IDX_W-1:0];
        l_waddr = free_head[llsm_pkg::IDX_W-1:0];
        if (req_func == llsm_pkg::FN_PREPEND) begin
          l_we    = 1'b1;
          l_wdata = list_head;
        end else if (req_func == llsm_pkg::FN_APPEND) begin
          l_we    = 1'b1;
          l_wdata = llsm_pkg::POS_NONE;
        end else begin
          l_re = 1'b1;
        end
      end
      llsm_pkg::OP_APP_START: begin
        l_re    = 1'b1;
        rd_addr = list_head[llsm_pkg::IDX_W-1:0];
      end
      llsm_pkg::OP_APP_WALK: begin
        if (stat.app_more) begin
          l_re    = 1'b1;
          rd_addr = rd_link[llsm_pkg::IDX_W-1:0];
        end else begin
          l_we    = 1'b1;
          l_waddr = cur[llsm_pkg::IDX_W-1:0];
          l_wdata = s_slot;
        end
      end
      llsm_pkg::OP_INS_W1: begin
        l_we    = 1'b1;
        l_waddr = s_slot[llsm_pkg::IDX_W-1:0];
        l_wdata = rd_link;
      end
      llsm_pkg::OP_INS_W2: begin
        l_we    = 1'b1;
        l_waddr = req_pos[llsm_pkg::IDX_W-1:0];
        l_wdata = s_slot;
      end
      llsm_pkg::OP_RM_RD: begin
        l_re = 1'b1;
        v_re = 1'b1;
      end
      llsm_pkg::OP_RM_WALK: begin
        l_re    = stat.rm_more;
        rd_addr = cur_w[llsm_pkg::IDX_W-1:0];
      end
      llsm_pkg::OP_RM_FIX: begin
        l_we    = (prev != llsm_pkg::POS_NONE);
        l_waddr = prev[llsm_pkg::IDX_W-1:0];
        l_wdata = succ;
      end
      llsm_pkg::OP_RM_FREE: begin
        l_we    = 1'b1;
        l_waddr = req_pos[llsm_pkg::IDX_W-1:0];
        l_wdata = free_head;
      end
      llsm_pkg::OP_SR_START: begin
        l_re    = 1'b1;
        v_re    = 1'b1;
        rd_addr = list_head[llsm_pkg::IDX_W-1:0];
      end
      llsm_pkg::OP_SR_STEP: begin
        l_re    = !stat.hit && stat.sr_more;
        v_re    = !stat.hit && stat.sr_more;
        rd_addr = rd_link[llsm_pkg::IDX_W-1:0];
      end
      default: begin
        if (cmd.get_final) begin
          v_we = (req_func == llsm_pkg::FN_SET);
        end else if (cmd.op == llsm_pkg::OP_NONE && req_func != llsm_pkg::FN_UNUSED) begin
          v_re = 1'b0;
        end
      end
    endcase
    if (cmd.op == llsm_pkg::OP_FAIL && cmd.get_final) begin
      v_re = 1'b1;
    end
  end

  llsm_ram #(.WIDTH(llsm_pkg::POS_W), .DEPTH(llsm_pkg::SLOTS)) u_links (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(rd_addr), .rdata(l_rdata)
  );

  llsm_ram #(.WIDTH(llsm_pkg::VAL_W), .DEPTH(llsm_pkg::SLOTS)) u_values (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .re(v_re), .raddr(rd_addr), .rdata(v_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      list_head <= llsm_pkg::POS_NONE;
      free_head <= '0;
      count     <= '0;
      in_use    <= '0;
      lvld      <= '0;
      use_rd    <= 1'b0;
    end else begin
      if (l_we) begin
        lvld[l_waddr] <= 1'b1;
      end
      case (cmd.op)
        llsm_pkg::OP_TAKE: begin
          free_head <= rd_link[llsm_pkg::POS_W-1] ? llsm_pkg::POS_NONE : rd_link;
          in_use[free_head[llsm_pkg::IDX_W-1:0]] <= 1'b1;
          count <= count + 1'b1;
          if (req_func == llsm_pkg::FN_PREPEND ||
              (req_func == llsm_pkg::FN_APPEND && !stat.head_ok)) begin
            list_head <= free_head;
          end
        end
        llsm_pkg::OP_RM_LATCH: use_rd <= 1'b0;
        llsm_pkg::OP_RM_WALK: begin
          if (stat.rm_more) begin
            use_rd <= 1'b1;
          end
        end
        llsm_pkg::OP_RM_FIX: begin
          if (prev == llsm_pkg::POS_NONE) begin
            list_head <= succ;
          end
        end
        llsm_pkg::OP_RM_FREE: begin
          free_head <= req_pos;
          in_use[req_pos[llsm_pkg::IDX_W-1:0]] <= 1'b0;
          if (count != '0) begin
            count <= count - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (l_re) begin
      lvld_q <= lvld[rd_addr];
      ldef_q <= (rd_addr == llsm_pkg::IDX_W'(llsm_pkg::SLOTS - 1)) ? llsm_pkg::POS_NONE
                : {1'b0, rd_addr} + 1'b1;
    end
    case (cmd.op)
      llsm_pkg::OP_LOAD: begin
        req_func <= llsm_pkg::func_t'(func);
        req_pos  <= position;
        req_val  <= value;
        n        <= '0;
      end
      llsm_pkg::OP_FAIL: begin
        if (cmd.get_final) begin
          res_status <= llsm_pkg::ST_OK;
          res_pos    <= req_pos;
          res_val    <= v_rdata;
        end else begin
          res_status <= cmd.code;
          res_pos    <= llsm_pkg::POS_NONE;
          res_val    <= '0;
        end
      end
      llsm_pkg::OP_TAKE: begin
        s_slot     <= free_head;
        res_status <= llsm_pkg::ST_OK;
        res_pos    <= free_head;
        res_val    <= '0;
      end
      llsm_pkg::OP_APP_START: begin
        cur <= list_head;
        n   <= '0;
      end
      llsm_pkg::OP_APP_WALK: begin
        if (stat.app_more) begin
          cur <= rd_link;
          n   <= n + 1'b1;
        end
      end
      llsm_pkg::OP_RM_LATCH: begin
        res_val <= v_rdata;
        succ    <= rd_link[llsm_pkg::POS_W-1] ? llsm_pkg::POS_NONE : rd_link;
        prev    <= llsm_pkg::POS_NONE;
        cur     <= list_head;
        n       <= '0;
      end
      llsm_pkg::OP_RM_WALK: begin
        if (stat.rm_more) begin
          prev <= cur_w;
          n    <= n + 1'b1;
        end
      end
      llsm_pkg::OP_RM_FREE: begin
        res_status <= llsm_pkg::ST_OK;
        res_pos    <= succ;
      end
      llsm_pkg::OP_SR_START: begin
        cur <= list_head;
        n   <= '0;
      end
      llsm_pkg::OP_SR_STEP: begin
        if (stat.hit) begin
          res_status <= llsm_pkg::ST_OK;
          res_pos    <= cur;
          res_val    <= req_val;
        end else if (stat.sr_more) begin
          cur <= rd_link;
          n   <= n + 1'b1;
        end else begin
          res_status <= llsm_pkg::ST_NOT_FOUND;
          res_pos    <= llsm_pkg::POS_NONE;
          res_val    <= '0;
        end
      end
      default: ;
    endcase
  end

  assign status       = res_status;
  assign out_position = res_pos;
  assign out_value    = res_val;
  assign list_size    = count;

`ifndef ASSERT_OFF
  a_count_matches_use: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == 32'(count))
    else $error("element count disagrees with occupancy");
  a_take_has_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == llsm_pkg::OP_TAKE |-> stat.free_ok)
    else $error("slot taken from empty free list");
  a_free_in_use: assert property (@(posedge clk) disable iff (rst)
    cmd.op == llsm_pkg::OP_RM_FREE |-> in_use[req_pos[llsm_pkg::IDX_W-1:0]])
    else $error("freeing a slot not in use");
  a_take_marks_use: assert property (@(posedge clk) disable iff (rst)
    cmd.op == llsm_pkg::OP_TAKE |=> in_use[s_slot[llsm_pkg::IDX_W-1:0]])
    else $error("taken slot not marked in use");
`endif

endmodule

// ===== rtl/llsm_ctrl.sv =====
// Controller state machine: sequences each request through datapath commands.
// Depends on llsm_pkg; talks to llsm_datapath through dp_cmd_t and dp_stat_t.
module llsm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  llsm_pkg::dp_stat_t stat,
  output llsm_pkg::dp_cmd_t  cmd
);

  llsm_pkg::ctl_state_t state;
  llsm_pkg::ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llsm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.op        = llsm_pkg::OP_NONE;
    cmd.code      = llsm_pkg::ST_BAD_POS;
    cmd.get_final = 1'b0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state)
      llsm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = llsm_pkg::OP_LOAD;
          state_next = llsm_pkg::S_DISPATCH;
        end
      end
      llsm_pkg::S_DISPATCH: begin
        state_next = llsm_pkg::S_DONE;
        cmd.op     = llsm_pkg::OP_FAIL;
        case (stat.func)
          llsm_pkg::FN_APPEND, llsm_pkg::FN_PREPEND: begin
            cmd.code = llsm_pkg::ST_FULL;
            if (stat.free_ok) begin
              cmd.op     = llsm_pkg::OP_TAKE_RD;
              state_next = llsm_pkg::S_TAKE;
            end
          end
          llsm_pkg::FN_INSERT: begin
            if (stat.pos_ok) begin
              cmd.code = llsm_pkg::ST_FULL;
              if (stat.free_ok) begin
                cmd.op     = llsm_pkg::OP_TAKE_RD;
                state_next = llsm_pkg::S_TAKE;
              end
            end
          end
          llsm_pkg::FN_REMOVE: begin
            if (stat.pos_ok) begin
              cmd.op     = llsm_pkg::OP_RM_RD;
              state_next = llsm_pkg::S_RM_LATCH;
            end
          end
          llsm_pkg::FN_SEARCH: begin
            cmd.code = llsm_pkg::ST_NOT_FOUND;
            if (stat.head_ok) begin
              cmd.op     = llsm_pkg::OP_SR_START;
              state_next = llsm_pkg::S_SR_STEP;
            end
          end
          llsm_pkg::FN_GET, llsm_pkg::FN_SET: begin
            if (stat.pos_ok) begin
              cmd.op     = llsm_pkg::OP_RM_RD;
              state_next = llsm_pkg::S_GET;
            end
          end
          default: ;
        endcase
      end
      llsm_pkg::S_TAKE: begin
        cmd.op = llsm_pkg::OP_TAKE;
        case (stat.func)
          llsm_pkg::FN_APPEND:
            state_next = stat.head_ok ? llsm_pkg::S_APP_START : llsm_pkg::S_DONE;
          llsm_pkg::FN_INSERT: state_next = llsm_pkg::S_INS_W1;
          default: state_next = llsm_pkg::S_DONE;
        endcase
      end
      llsm_pkg::S_APP_START: begin
        cmd.op     = llsm_pkg::OP_APP_START;
        state_next = llsm_pkg::S_APP_WALK;
      end
      llsm_pkg::S_APP_WALK: begin
        cmd.op = llsm_pkg::OP_APP_WALK;
        if (!stat.app_more) begin
          state_next = llsm_pkg::S_DONE;
        end
      end
      llsm_pkg::S_INS_W1: begin
        cmd.op     = llsm_pkg::OP_INS_W1;
        state_next = llsm_pkg::S_INS_W2;
      end
      llsm_pkg::S_INS_W2: begin
        cmd.op     = llsm_pkg::OP_INS_W2;
        state_next = llsm_pkg::S_DONE;
      end
      llsm_pkg::S_RM_LATCH: begin
        cmd.op     = llsm_pkg::OP_RM_LATCH;
        state_next = llsm_pkg::S_RM_WALK;
      end
      llsm_pkg::S_RM_WALK: begin
        cmd.op = llsm_pkg::OP_RM_WALK;
        if (!stat.rm_more) begin
          state_next = llsm_pkg::S_RM_FIX;
        end
      end
      llsm_pkg::S_RM_FIX: begin
        cmd.op     = llsm_pkg::OP_RM_FIX;
        state_next = llsm_pkg::S_RM_FREE;
      end
      llsm_pkg::S_RM_FREE: begin
        cmd.op     = llsm_pkg::OP_RM_FREE;
        state_next = llsm_pkg::S_DONE;
      end
      llsm_pkg::S_SR_STEP: begin
        cmd.op = llsm_pkg::OP_SR_STEP;
        if (stat.hit || !stat.sr_more) begin
          state_next = llsm_pkg::S_DONE;
        end
      end
      llsm_pkg::S_GET: begin
        cmd.op        = llsm_pkg::OP_FAIL;
        cmd.get_final = 1'b1;
        state_next    = llsm_pkg::S_DONE;
      end
      llsm_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = llsm_pkg::S_IDLE;
        end
      end
      default: state_next = llsm_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/linked_list_slot_manager_top.sv =====
// Top level of the linked list slot manager: controller plus datapath.
// Depends on llsm_pkg, llsm_req_if, llsm_rsp_if, llsm_ctrl and llsm_datapath.
//
//   channel | dir | payload
//   req     | in  | func, position, value
//   rsp     | out | status, out_position, out_value, list_size
//
// One request at a time: accept, work, hold the response until taken.
// Append, remove and search walk the link RAM, one slot read per cycle,
// bounded by the single read port of the link RAM.
// Reset is synchronous and active high; no clearing pass, links default by valid bits.
// A stalled response holds its beat; no new request is accepted meanwhile.
module linked_list_slot_manager_top (
  input logic         clk,
  input logic         rst,
  llsm_req_if.sink    req,
  llsm_rsp_if.source  rsp
);

  llsm_pkg::dp_cmd_t  cmd;
  llsm_pkg::dp_stat_t stat;

  llsm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .stat(stat), .cmd(cmd)
  );

  llsm_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .func(req.func), .position(req.position), .value(req.value),
    .stat(stat),
    .status(rsp.status), .out_position(rsp.out_position),
    .out_value(rsp.out_value), .list_size(rsp.list_size)
  );

endmodule
